// ===== rtl/core/pal_pkg.sv =====
// Package for the positional array list: sizes, field and command codes,
// the request, response and cell command structs, and the word conversion.
// Used by pal_cell and positional_array_list_unit; depends on nothing.
`default_nettype none

package pal_pkg;

   localparam int CAPACITY  = 16;
   localparam int WORD_BITS = 32;

   // Index of one slot, and a count that can also hold CAPACITY itself.
   localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);

   // Fixed widths of the channel fields.
   localparam int MODE_BITS   = 2;
   localparam int POS_BITS    = 5;
   localparam int VALUE_BITS  = 32;
   localparam int STATUS_BITS = 2;

   // Width used to compare positions against counts without overflow.
   localparam int CMP_BITS = ((POS_BITS > CNT_BITS) ? POS_BITS : CNT_BITS) + 1;

   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_LOCATE = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_SORTED = 2'd3;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_POS   = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_DELETE = 2'd2;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]         mode;
      logic [POS_BITS-1:0]          position;
      logic signed [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [POS_BITS-1:0]    found_position;
      logic [POS_BITS-1:0]    entry_count;
   } rsp_type;

   // Broadcast to every cell. For an insert, slot takes the new word and
   // cells above it up to top take their lower neighbor. For a delete,
   // cells from slot below top take their upper neighbor and top clears.
   typedef struct packed {
      logic [1:0]          op;
      logic [IDX_BITS-1:0] slot;
      logic [IDX_BITS-1:0] top;
      word_type            value;
   } cell_cmd_type;

   // Sign-extends (or truncates) the request value to the list word width.
   function automatic word_type to_word(input logic signed [VALUE_BITS-1:0] v);
      return WORD_BITS'(v);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pal_cell.sv =====
// One slot of the list: holds an entry, shifts to or from its neighbors on
// a broadcast command, and registers equal / greater flags against a search word.
// Depends on pal_pkg.
`default_nettype none

module pal_cell
   import pal_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [IDX_BITS-1:0] cell_index,
   input  wire cell_cmd_type        cmd,
   input  wire word_type            lower_entry,
   input  wire word_type            upper_entry,
   input  wire logic [CNT_BITS-1:0] count,
   input  wire word_type            search,
   output word_type                 entry,
   output logic                     eq_flag,
   output logic                     gt_flag
);

   word_type entry_ff, entry_in;
   logic     eq_ff, eq_in;
   logic     gt_ff, gt_in;
   logic     valid;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (cell_index == cmd.slot) begin
               entry_in = cmd.value;
            end else if (cell_index > cmd.slot && cell_index <= cmd.top) begin
               entry_in = lower_entry;
            end
         end
         CELL_DELETE: begin
            if (cell_index >= cmd.slot && cell_index < cmd.top) begin
               entry_in = upper_entry;
            end else if (cell_index == cmd.top) begin
               entry_in = '0;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Only slots below the count take part in a search.
   assign valid = CNT_BITS'(cell_index) < count;
   assign eq_in = valid && (entry_ff == search);
   assign gt_in = valid && ($signed(entry_ff) > $signed(search));

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         eq_ff    <= 1'b0;
         gt_ff    <= 1'b0;
      end else begin
         entry_ff <= entry_in;
         eq_ff    <= eq_in;
         gt_ff    <= gt_in;
      end
   end

   assign entry   = entry_ff;
   assign eq_flag = eq_ff;
   assign gt_flag = gt_ff;

endmodule

`default_nettype wire

// ===== rtl/core/positional_array_list_unit.sv =====
// Positional array list unit: a fixed-capacity ordered list of signed words
// held in a chain of pal_cell slots. Depends on pal_pkg and pal_cell.
//
// Usage: a request transfer on req_ (valid/stall) carries mode, position
// and value. Mode selects insert at a one-based position, delete at a
// position, locate the first equal entry, or insert in ascending order.
// Each request yields exactly one response transfer on rsp_ with a status
// (ok, full, bad position, not found), the found position for a locate,
// and the entry count after the operation.
// Sequence: the request is registered, then in the compare state every cell
// compares its entry with the registered value and registers its flags, and
// in the apply state the unit picks the first hit, shifts the cells and loads
// the response register, which sets rsp_valid. A new request is taken only
// after the apply step of the last one; req_stall is high while a request
// is in flight.
// The response sits in an output register, so a new request is taken while
// an earlier response still waits. If rsp_stall holds that register, the
// next request waits in its apply step until the response is taken.
// Reset clears the list to empty, all entries to zero, and drops rsp_valid.
`default_nettype none

module positional_array_list_unit
   import pal_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CMP   = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [MODE_BITS-1:0] mode_ff;
   logic [POS_BITS-1:0] pos_ff;
   word_type            word_ff;

   cell_cmd_type        cmd;
   word_type            cell_entry [CAPACITY];
   logic [CAPACITY-1:0] eq_flags;
   logic [CAPACITY-1:0] gt_flags;

   logic                req_take;
   logic                apply_fire;
   logic                eq_hit, gt_hit;
   logic [IDX_BITS-1:0] eq_idx, gt_idx;
   logic [CMP_BITS-1:0] pos_ext, count_ext;
   logic                full;

   // Chain of cells; each hands its entry to both neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type lower, upper;
      if (i == 0) begin : g_first
         assign lower = '0;
      end else begin : g_lower
         assign lower = cell_entry[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign upper = '0;
      end else begin : g_upper
         assign upper = cell_entry[i+1];
      end
      pal_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cell_index  (IDX_BITS'(i)),
         .cmd         (cmd),
         .lower_entry (lower),
         .upper_entry (upper),
         .count       (count_ff),
         .search      (word_ff),
         .entry       (cell_entry[i]),
         .eq_flag     (eq_flags[i]),
         .gt_flag     (gt_flags[i])
      );
   end

   // First set flag, lowest slot wins.
   always_comb begin
      eq_idx = '0;
      gt_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (eq_flags[i]) begin
            eq_idx = IDX_BITS'(i);
         end
         if (gt_flags[i]) begin
            gt_idx = IDX_BITS'(i);
         end
      end
   end

   assign eq_hit    = |eq_flags;
   assign gt_hit    = |gt_flags;
   assign pos_ext   = CMP_BITS'(pos_ff);
   assign count_ext = CMP_BITS'(count_ff);
   assign full      = count_ff == CNT_BITS'(CAPACITY);

   assign req_take   = req_valid && !req_stall;
   assign apply_fire = (state_ff == ST_APPLY) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cmd.op    = CELL_HOLD;
      cmd.slot  = '0;
      cmd.top   = '0;
      cmd.value = word_ff;
      count_in  = count_ff;
      rsp_in    = rsp_ff;
      if (apply_fire) begin
         rsp_in.status         = STATUS_OK;
         rsp_in.found_position = '0;
         case (mode_ff)
            MODE_INSERT: begin
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else if (pos_ff == '0 || pos_ext > count_ext + 1'b1) begin
                  rsp_in.status = STATUS_BAD_POS;
               end else begin
                  cmd.op   = CELL_INSERT;
                  cmd.slot = IDX_BITS'(pos_ext - 1'b1);
                  cmd.top  = IDX_BITS'(count_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            MODE_DELETE: begin
               if (pos_ff == '0 || pos_ext > count_ext) begin
                  rsp_in.status = STATUS_BAD_POS;
               end else begin
                  cmd.op   = CELL_DELETE;
                  cmd.slot = IDX_BITS'(pos_ext - 1'b1);
                  cmd.top  = IDX_BITS'(count_ff - 1'b1);
                  count_in = count_ff - 1'b1;
               end
            end
            MODE_LOCATE: begin
               if (eq_hit) begin
                  rsp_in.found_position = POS_BITS'(CNT_BITS'(eq_idx) + 1'b1);
               end else begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end
            end
            MODE_SORTED: begin
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  cmd.op   = CELL_INSERT;
                  cmd.slot = gt_hit ? gt_idx : IDX_BITS'(count_ff);
                  cmd.top  = IDX_BITS'(count_ff);
                  count_in = count_ff + 1'b1;
               end
            end
            default: begin
               rsp_in.status = STATUS_OK;
            end
         endcase
         rsp_in.entry_count = POS_BITS'(count_in);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (apply_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (apply_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_take) begin
         mode_ff <= req_payload.mode;
         pos_ff  <= req_payload.position;
         word_ff <= to_word(req_payload.value);
      end
   end

   assign req_stall   = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
